// ----- rtl/irs_pkg.sv -----
// ----------------------------------------------------------------------------
// irs_pkg
// Shared types, constants and the axis mapping function of the image resizer.
// ----------------------------------------------------------------------------
package irs_pkg;

   // configuration register indexes
   typedef enum logic [2:0] {
      REG_SRC_WIDTH  = 3'd0,
      REG_SRC_HEIGHT = 3'd1,
      REG_DST_WIDTH  = 3'd2,
      REG_DST_HEIGHT = 3'd3,
      REG_COL_STEP   = 3'd4,
      REG_ROW_STEP   = 3'd5
   } reg_index_type;

   // resize modes
   typedef enum logic [2:0] {
      MODE_COPY     = 3'd0,
      MODE_BOX2     = 3'd1,
      MODE_BOX4     = 3'd2,
      MODE_BOX8     = 3'd3,
      MODE_NEAREST  = 3'd4,
      MODE_BILINEAR = 3'd5
   } mode_type;

   localparam int          DEF_MAX_SRC_WIDTH = 4096;
   localparam int          DEF_MAX_UPSCALE   = 4;
   localparam logic [12:0] RST_SRC_WIDTH     = 13'd640;
   localparam logic [12:0] RST_SRC_HEIGHT    = 13'd480;
   localparam logic [14:0] RST_DST_WIDTH     = 15'd320;
   localparam logic [14:0] RST_DST_HEIGHT    = 15'd240;
   localparam logic [28:0] RST_STEP          = 29'h0020000;
   localparam logic [28:0] STEP_MAX          = 29'h10000000;
   localparam logic [14:0] DST_MAX           = 15'd16384;

   // result of mapping one destination index onto one source axis
   typedef struct packed {
      logic        ok;
      logic [11:0] base;
      logic [11:0] trig;
      logic [15:0] frac;
   } axis_map_type;

   function automatic axis_map_type axis_map(input mode_type mode, input logic [15:0] d,
                                             input logic [33:0] pos, input logic [12:0] size);
      axis_map_type res;
      logic [17:0]  f;
      logic [17:0]  b;
      logic [17:0]  b1;
      logic [17:0]  last;
      f    = pos[33:16];
      last = {5'd0, size} - 18'd1;
      res  = '0;
      b    = '0;
      unique case (mode)
         MODE_COPY: begin
            res.ok   = {2'd0, d} < {5'd0, size};
            res.base = d[11:0];
            res.trig = d[11:0];
         end
         MODE_BOX2, MODE_BOX4, MODE_BOX8: begin
            b  = {3'd0, d[14:0]} << mode[1:0];
            b  = (b != '0) ? b - 18'd1 : '0;
            b1 = b + 18'd1;
            res.ok   = b < {5'd0, size};
            res.base = b[11:0];
            res.trig = (b1 < {5'd0, size}) ? b1[11:0] : last[11:0];
         end
         MODE_NEAREST: begin
            b = f;
            if (pos[15]) begin
               b = f + 18'd1;
            end
            if (b > last) begin
               b = last;
            end
            res.ok   = f < {5'd0, size};
            res.base = b[11:0];
            res.trig = b[11:0];
         end
         default: begin
            b1 = f + 18'd1;
            res.ok   = f < {5'd0, size};
            res.base = f[11:0];
            res.trig = (b1 < {5'd0, size}) ? b1[11:0] : last[11:0];
            res.frac = pos[15:0];
         end
      endcase
      return res;
   endfunction

endpackage

// ----- rtl/irs_ram.sv -----
// ----------------------------------------------------------------------------
// irs_ram
// Generic RAM, one write port and two read ports with registered read data.
// ----------------------------------------------------------------------------
module irs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write and registered reads
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end

endmodule

// ----- rtl/image_resize_stream.sv -----
// Sequence: an accepted request passes ST_LOAD, the row scan ST_ROWS and the column
// scan ST_COLS (nr, nc up to 2*MAX_UPSCALE destination rows and columns), then ST_EA,
// ST_EB and ST_EC to ST_OUT, where rsp_tvalid holds until rsp_tready; each further
// result repeats ST_EA to ST_OUT. Requests: a new one is taken only in ST_IDLE, after
// the last result and the write-back of the previous request.
// Reset: synchronous, clears counters, positions and the state machine, loads the
// configuration defaults; the line store holds no valid data until a row is written.
// ----------------------------------------------------------------------------
// image_resize_stream
// Streaming 8-bit image resizer: copy, box average, nearest or bilinear.
// ----------------------------------------------------------------------------
module image_resize_stream #(
   parameter int MAX_SRC_WIDTH = irs_pkg::DEF_MAX_SRC_WIDTH,
   parameter int MAX_UPSCALE   = irs_pkg::DEF_MAX_UPSCALE
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] pixel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [7:0] out_pixel, [21:8] out_col, [35:22] out_row
   output logic        rsp_tlast,
   output logic        rsp_tuser,   // [0] last_of_frame
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [28:0] csr_wdata
);

   localparam int          GROUP = 2 * MAX_UPSCALE;
   localparam int          IW    = $clog2(GROUP + 1);
   localparam int          AW    = $clog2(MAX_SRC_WIDTH);
   localparam int          MAXW  = (MAX_SRC_WIDTH < 4096) ? MAX_SRC_WIDTH : 4096;
   localparam logic [28:0] SMIN  = 29'(65536 / MAX_UPSCALE);

   typedef enum logic [8:0] {
      ST_IDLE = 9'b000000001,
      ST_LOAD = 9'b000000010,
      ST_ROWS = 9'b000000100,
      ST_COLS = 9'b000001000,
      ST_EA   = 9'b000010000,
      ST_EB   = 9'b000100000,
      ST_EC   = 9'b001000000,
      ST_OUT  = 9'b010000000,
      ST_WB   = 9'b100000000
   } state_type;

   state_type   state_ff, state_in;

   // configuration
   logic [12:0] src_width_ff, src_height_ff;
   logic [14:0] dst_width_ff, dst_height_ff;
   logic [28:0] col_step_ff, row_step_ff;

   // frame state
   logic [7:0]  left_pixel_ff, left_pixel_in;
   logic [11:0] col_count_ff, col_count_in, row_count_ff, row_count_in;
   logic [14:0] next_row_ff, next_row_in, next_col_ff, next_col_in;
   logic [31:0] row_pos_ff, row_pos_in, col_pos_ff, col_pos_in;

   // per-request work registers
   logic [7:0]  pix_ff, pix_in, q00_ff, q00_in, q01_ff, q01_in;
   logic [IW-1:0] idx_ff, idx_in, nr_ff, nr_in, nc_ff, nc_in, ri_ff, ri_in, ci_ff, ci_in;
   logic [33:0] scan_ff, scan_in, rpos_ff, rpos_in, cpos_ff, cpos_in;
   logic [31:0] rend_ff, rend_in, cend_ff, cend_in;
   logic        wb2_ff, wb2_in;

   // emit pipeline registers
   logic [7:0]  p00_ff, p01_ff, p10_ff, p11_ff;
   logic [15:0] wx_ff, wy_ff;
   logic [13:0] ox_ff, oy_ff;
   logic        olast_ff, oframe_ff;
   logic [24:0] top_ff, bot_ff;
   logic [7:0]  rsp_pixel_ff;
   logic [13:0] rsp_col_ff, rsp_row_ff;
   logic        rsp_last_ff, rsp_frame_ff;

   // clamped sizes and steps, mode
   logic [12:0] sw, sh;
   logic [14:0] dw, dh;
   logic [28:0] cs, rs;
   irs_pkg::mode_type mode;
   logic        last_col, last_row;

   always_comb begin
      sw = (src_width_ff == '0) ? 13'd1 :
           ({19'd0, src_width_ff} > 32'(MAXW)) ? 13'(MAXW) : src_width_ff;
      sh = (src_height_ff == '0) ? 13'd1 : (src_height_ff > 13'd4096) ? 13'd4096 : src_height_ff;
      dw = (dst_width_ff == '0) ? 15'd1 :
           (dst_width_ff > irs_pkg::DST_MAX) ? irs_pkg::DST_MAX : dst_width_ff;
      dh = (dst_height_ff == '0) ? 15'd1 :
           (dst_height_ff > irs_pkg::DST_MAX) ? irs_pkg::DST_MAX : dst_height_ff;
      cs = (col_step_ff < SMIN) ? SMIN :
           (col_step_ff > irs_pkg::STEP_MAX) ? irs_pkg::STEP_MAX : col_step_ff;
      rs = (row_step_ff < SMIN) ? SMIN :
           (row_step_ff > irs_pkg::STEP_MAX) ? irs_pkg::STEP_MAX : row_step_ff;
      priority if ({2'd0, sh} == {3'd0, dh} && {2'd0, sw} == {3'd0, dw}) begin
         mode = irs_pkg::MODE_COPY;
      end else if ({5'd0, sh} == {2'd0, dh, 1'b0} && {5'd0, sw} == {2'd0, dw, 1'b0}) begin
         mode = irs_pkg::MODE_BOX2;
      end else if ({5'd0, sh} == {1'd0, dh, 2'b0} && {5'd0, sw} == {1'd0, dw, 2'b0}) begin
         mode = irs_pkg::MODE_BOX4;
      end else if ({5'd0, sh} == {dh, 3'b0} && {5'd0, sw} == {dw, 3'b0}) begin
         mode = irs_pkg::MODE_BOX8;
      end else if ({2'd0, sh} >= {3'd0, dh}) begin
         mode = irs_pkg::MODE_NEAREST;
      end else begin
         mode = irs_pkg::MODE_BILINEAR;
      end
      last_col = {1'b0, col_count_ff} >= sw - 13'd1;
      last_row = {1'b0, row_count_ff} >= sh - 13'd1;
   end

   // line store
   logic          ram_we;
   logic [AW-1:0] ram_waddr, rd_addr_a, rd_addr_b;
   logic [7:0]    ram_wdata, rd_data_a, rd_data_b;
   logic [11:0]   col_prev;

   assign col_prev  = col_count_ff - 12'd1;
   assign rd_addr_a = AW'(col_prev);
   assign rd_addr_b = AW'(col_count_ff);

   irs_ram #(
      .WIDTH (8),
      .DEPTH (MAX_SRC_WIDTH)
   ) u_line (
      .clock     (clock),
      .wr_en     (ram_we),
      .wr_addr   (ram_waddr),
      .wr_data   (ram_wdata),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (rd_data_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_b (rd_data_b)
   );

   // scan mapping: one candidate row or column per cycle
   irs_pkg::axis_map_type scan_map;
   logic [15:0] scan_d;
   logic        scan_ok;

   always_comb begin
      if (state_ff == ST_ROWS) begin
         scan_d   = {1'b0, next_row_ff} + 16'(idx_ff);
         scan_map = irs_pkg::axis_map(mode, scan_d, scan_ff, sh);
         scan_ok  = scan_d < {1'b0, dh} && scan_map.ok && scan_map.trig == row_count_ff;
      end else begin
         scan_d   = {1'b0, next_col_ff} + 16'(idx_ff);
         scan_map = irs_pkg::axis_map(mode, scan_d, scan_ff, sw);
         scan_ok  = scan_d < {1'b0, dw} && scan_map.ok && scan_map.trig == col_count_ff;
      end
   end

   // emit mapping and window selection
   irs_pkg::axis_map_type rmap, cmap;
   logic [15:0] ey, ex;
   logic        ti, li;
   logic [7:0]  e00, e01, e10;

   always_comb begin
      ey   = {1'b0, next_row_ff} + 16'(ri_ff);
      ex   = {1'b0, next_col_ff} + 16'(ci_ff);
      rmap = irs_pkg::axis_map(mode, ey, rpos_ff, sh);
      cmap = irs_pkg::axis_map(mode, ex, cpos_ff, sw);
      ti   = rmap.base == row_count_ff;
      li   = cmap.base == col_count_ff;
      e00  = ti ? (li ? pix_ff : left_pixel_ff) : (li ? q01_ff : q00_ff);
      e01  = ti ? pix_ff : q01_ff;
      e10  = li ? pix_ff : left_pixel_ff;
   end

   // final value
   logic [16:0] cwx, cwy;
   logic [39:0] acc;
   logic [9:0]  box_sum;
   logic [7:0]  value;

   always_comb begin
      cwx     = 17'h10000 - {1'b0, wx_ff};
      cwy     = 17'h10000 - {1'b0, wy_ff};
      acc     = 40'(top_ff * cwy) + 40'(bot_ff * {1'b0, wy_ff});
      box_sum = 10'(p00_ff) + 10'(p01_ff) + 10'(p10_ff) + 10'(p11_ff);
      unique case (mode)
         irs_pkg::MODE_COPY, irs_pkg::MODE_NEAREST: value = pix_ff;
         irs_pkg::MODE_BOX2, irs_pkg::MODE_BOX4, irs_pkg::MODE_BOX8: value = box_sum[9:2];
         default: value = acc[39:32];
      endcase
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      pix_in        = pix_ff;
      q00_in        = q00_ff;
      q01_in        = q01_ff;
      idx_in        = idx_ff;
      nr_in         = nr_ff;
      nc_in         = nc_ff;
      ri_in         = ri_ff;
      ci_in         = ci_ff;
      scan_in       = scan_ff;
      rpos_in       = rpos_ff;
      cpos_in       = cpos_ff;
      rend_in       = rend_ff;
      cend_in       = cend_ff;
      wb2_in        = wb2_ff;
      left_pixel_in = left_pixel_ff;
      col_count_in  = col_count_ff;
      row_count_in  = row_count_ff;
      next_row_in   = next_row_ff;
      next_col_in   = next_col_ff;
      row_pos_in    = row_pos_ff;
      col_pos_in    = col_pos_ff;
      ram_we        = 1'b0;
      ram_waddr     = AW'(col_prev);
      ram_wdata     = left_pixel_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               pix_in   = req_tdata;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            q00_in   = (col_count_ff != '0) ? rd_data_a : 8'd0;
            q01_in   = rd_data_b;
            idx_in   = '0;
            nr_in    = '0;
            scan_in  = {2'd0, row_pos_ff};
            state_in = ST_ROWS;
         end
         ST_ROWS: begin
            if (scan_ok) begin
               nr_in   = idx_ff + IW'(1);
               idx_in  = idx_ff + IW'(1);
               scan_in = scan_ff + {5'd0, rs};
            end
            if (!scan_ok || idx_ff == IW'(GROUP - 1)) begin
               rend_in  = scan_ok ? 32'(scan_ff + {5'd0, rs}) : scan_ff[31:0];
               idx_in   = '0;
               nc_in    = '0;
               scan_in  = {2'd0, col_pos_ff};
               state_in = ST_COLS;
            end
         end
         ST_COLS: begin
            if (scan_ok) begin
               nc_in   = idx_ff + IW'(1);
               idx_in  = idx_ff + IW'(1);
               scan_in = scan_ff + {5'd0, cs};
            end
            if (!scan_ok || idx_ff == IW'(GROUP - 1)) begin
               cend_in = scan_ok ? 32'(scan_ff + {5'd0, cs}) : scan_ff[31:0];
               ri_in   = '0;
               ci_in   = '0;
               rpos_in = {2'd0, row_pos_ff};
               cpos_in = {2'd0, col_pos_ff};
               if (nr_ff == '0 || (!scan_ok && idx_ff == '0)) begin
                  wb2_in   = 1'b0;
                  state_in = ST_WB;
               end else begin
                  state_in = ST_EA;
               end
            end
         end
         ST_EA: state_in = ST_EB;
         ST_EB: state_in = ST_EC;
         ST_EC: state_in = ST_OUT;
         ST_OUT: begin
            if (rsp_tready) begin
               if (ci_ff == nc_ff - IW'(1)) begin
                  ci_in   = '0;
                  cpos_in = {2'd0, col_pos_ff};
                  ri_in   = ri_ff + IW'(1);
                  rpos_in = rpos_ff + {5'd0, rs};
               end else begin
                  ci_in   = ci_ff + IW'(1);
                  cpos_in = cpos_ff + {5'd0, cs};
               end
               if (rsp_last_ff) begin
                  wb2_in   = 1'b0;
                  state_in = ST_WB;
               end else begin
                  state_in = ST_EA;
               end
            end
         end
         ST_WB: begin
            if (!wb2_ff) begin
               // left neighbor goes back into the line store
               ram_we = col_count_ff != '0;
               wb2_in = 1'b1;
            end else begin
               // last column also stores the new pixel, then counters advance
               ram_we        = last_col;
               ram_waddr     = AW'(col_count_ff);
               ram_wdata     = pix_ff;
               left_pixel_in = pix_ff;
               next_col_in   = next_col_ff + 15'(nc_ff);
               col_pos_in    = cend_ff;
               col_count_in  = col_count_ff + 12'd1;
               if (last_col) begin
                  col_count_in = '0;
                  next_col_in  = '0;
                  col_pos_in   = '0;
                  if (last_row) begin
                     row_count_in = '0;
                     next_row_in  = '0;
                     row_pos_in   = '0;
                  end else begin
                     row_count_in = row_count_ff + 12'd1;
                     next_row_in  = next_row_ff + 15'(nr_ff);
                     row_pos_in   = rend_ff;
                  end
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         src_width_ff  <= irs_pkg::RST_SRC_WIDTH;
         src_height_ff <= irs_pkg::RST_SRC_HEIGHT;
         dst_width_ff  <= irs_pkg::RST_DST_WIDTH;
         dst_height_ff <= irs_pkg::RST_DST_HEIGHT;
         col_step_ff   <= irs_pkg::RST_STEP;
         row_step_ff   <= irs_pkg::RST_STEP;
         left_pixel_ff <= '0;
         col_count_ff  <= '0;
         row_count_ff  <= '0;
         next_row_ff   <= '0;
         next_col_ff   <= '0;
         row_pos_ff    <= '0;
         col_pos_ff    <= '0;
      end else begin
         state_ff      <= state_in;
         left_pixel_ff <= left_pixel_in;
         col_count_ff  <= col_count_in;
         row_count_ff  <= row_count_in;
         next_row_ff   <= next_row_in;
         next_col_ff   <= next_col_in;
         row_pos_ff    <= row_pos_in;
         col_pos_ff    <= col_pos_in;
         if (csr_we) begin
            unique case (csr_addr)
               irs_pkg::REG_SRC_WIDTH:  src_width_ff  <= csr_wdata[12:0];
               irs_pkg::REG_SRC_HEIGHT: src_height_ff <= csr_wdata[12:0];
               irs_pkg::REG_DST_WIDTH:  dst_width_ff  <= csr_wdata[14:0];
               irs_pkg::REG_DST_HEIGHT: dst_height_ff <= csr_wdata[14:0];
               irs_pkg::REG_COL_STEP:   col_step_ff   <= csr_wdata;
               irs_pkg::REG_ROW_STEP:   row_step_ff   <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // work and datapath registers
   always_ff @(posedge clock) begin
      pix_ff  <= pix_in;
      q00_ff  <= q00_in;
      q01_ff  <= q01_in;
      idx_ff  <= idx_in;
      nr_ff   <= nr_in;
      nc_ff   <= nc_in;
      ri_ff   <= ri_in;
      ci_ff   <= ci_in;
      scan_ff <= scan_in;
      rpos_ff <= rpos_in;
      cpos_ff <= cpos_in;
      rend_ff <= rend_in;
      cend_ff <= cend_in;
      wb2_ff  <= wb2_in;
      if (state_ff == ST_EA) begin
         p00_ff    <= e00;
         p01_ff    <= e01;
         p10_ff    <= e10;
         p11_ff    <= pix_ff;
         wx_ff     <= cmap.frac;
         wy_ff     <= rmap.frac;
         ox_ff     <= ex[13:0];
         oy_ff     <= ey[13:0];
         olast_ff  <= ri_ff == nr_ff - IW'(1) && ci_ff == nc_ff - IW'(1);
         oframe_ff <= ex == {1'b0, dw} - 16'd1 && ey == {1'b0, dh} - 16'd1;
      end
      // horizontal blend
      if (state_ff == ST_EB) begin
         top_ff <= 25'(p00_ff * cwx) + 25'(p01_ff * {1'b0, wx_ff});
         bot_ff <= 25'(p10_ff * cwx) + 25'(p11_ff * {1'b0, wx_ff});
      end
      if (state_ff == ST_EC) begin
         rsp_pixel_ff <= value;
         rsp_col_ff   <= ox_ff;
         rsp_row_ff   <= oy_ff;
         rsp_last_ff  <= olast_ff;
         rsp_frame_ff <= oframe_ff;
      end
   end

   assign req_tready = state_ff == ST_IDLE;
   assign rsp_tvalid = state_ff == ST_OUT;
   assign rsp_tdata  = {4'd0, rsp_row_ff, rsp_col_ff, rsp_pixel_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_frame_ff;

`ifndef SYNTH
   // no request taken while a result is pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request accepted while result pending");

   // line store written only during write-back
   a_we_wb: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> state_ff == ST_WB)
      else $error("line store write outside write-back");

   // emit indexes stay inside the counted block
   a_emit_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EA |-> ci_ff < nc_ff && ri_ff < nr_ff)
      else $error("emit index out of range");

   // last result of a request is followed by write-back
   a_last_wb: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> state_ff == ST_WB)
      else $error("missing write-back after last result");
`endif

endmodule
